// ----- rtl/mpid_pkg.sv -----
package mpid_pkg;

	localparam int OPERAND_W   = 63;
	localparam int RESULT_W    = 31;
	localparam int REQ_W       = 2;
	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 32;
	localparam int CNT_W       = $clog2(OPERAND_W + 1);
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [30:0] DEFAULT_MODULUS = 31'd1000000007;

	localparam logic REG_MODULUS = 1'b0;

	typedef enum logic [REQ_W-1:0] {
		OP_POWER   = 2'd0,
		OP_INVERSE = 2'd1,
		OP_DIVIDE  = 2'd2
	} op_t;

	typedef struct packed {
		logic start;
	} red_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} red_sts_t;

endpackage

// ----- rtl/mpid_cfg.sv -----
module mpid_cfg
	import mpid_pkg::*;
#(
	parameter int MOD_WIDTH = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [MOD_WIDTH-1:0]  modulus
);

	logic [MOD_WIDTH-1:0] modulus_q;
	logic                 hit;

	assign pready  = 1'b1;
	assign hit     = (paddr[APB_ADDR_W-1] == REG_MODULUS);
	assign modulus = modulus_q;
	assign prdata  = hit ? APB_DATA_W'(modulus_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= DEFAULT_MODULUS[MOD_WIDTH-1:0];
		end else if (psel && penable && pwrite && pready && hit) begin
			modulus_q <= pwdata[MOD_WIDTH-1:0];
		end
	end

endmodule

// ----- rtl/mpid_reduce.sv -----
module mpid_reduce
	import mpid_pkg::*;
#(
	parameter int MOD_WIDTH = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  red_ctl_t             ctl,
	input  logic [OPERAND_W-1:0] value,
	input  logic [MOD_WIDTH-1:0] modulus,
	output red_sts_t             sts,
	output logic [MOD_WIDTH-1:0] rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [OPERAND_W-1:0] val_q;
	logic [MOD_WIDTH-1:0] rem_q;
	logic [MOD_WIDTH:0]   trial;
	logic [MOD_WIDTH:0]   diff;
	logic [MOD_WIDTH-1:0] rem_next;

	assign trial    = {rem_q, val_q[OPERAND_W-1]};
	assign diff     = trial - {1'b0, modulus};
	assign rem_next = (trial >= {1'b0, modulus}) ? diff[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OPERAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << 1;
			rem_q <= rem_next;
		end
	end

endmodule

// ----- rtl/modular_power_inverse_divide.sv -----
// Sequence: the base (operand_b for divide, else operand_a) is reduced first, then each step is a modular multiply.
// Each multiply is one 31x31 product, zero-extended to 63 bits and reduced bit-serially, one bit per cycle.
// Power: (exponent bit length - 1) squarings plus one multiply per set bit.
// Inverse and divide follow the same loop over the bits of modulus-2 (divide adds two).
// Throughput: one transaction at a time; a finished result waits in the output register.
// Reset: arst_n clears all control state; modulus returns to 1000000007.
module modular_power_inverse_divide
	import mpid_pkg::*;
#(
	parameter int MOD_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // operand_a [62:0], operand_b [125:63]
	input  logic [REQ_W-1:0]       s_tuser,   // req_type [1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // result [30:0]
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_STEP  = 5'b00010,
		S_LOAD  = 5'b00100,
		S_WAIT  = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		K_BASE,
		K_ACC,
		K_SQR,
		K_AMOD,
		K_FIN
	} kind_t;

	state_t               state_q;
	kind_t                kind_q;
	op_t                  op_q;
	logic                 amod_q;
	logic                 out_valid_q;
	logic [OPERAND_W-1:0] a_q;
	logic [OPERAND_W-1:0] exp_q;
	logic [OPERAND_W-1:0] red_q;
	logic [MOD_WIDTH-1:0] base_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] res_q;
	logic [RESULT_W-1:0]  out_q;

	logic [MOD_WIDTH-1:0]   modulus;
	logic [MOD_WIDTH-1:0]   rem;
	red_ctl_t               red_ctl;
	red_sts_t               red_sts;
	logic [OPERAND_W-1:0]   red_val;
	logic [OPERAND_W-1:0]   op_a;
	logic [OPERAND_W-1:0]   op_b;
	logic                   accept;
	logic                   req_ok;
	logic                   out_free;
	logic [MOD_WIDTH-1:0]   mul_x;
	logic [2*MOD_WIDTH-1:0] prod;
	logic [MOD_WIDTH-1:0]   mod_m2;

	mpid_cfg #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.modulus (modulus)
	);

	mpid_reduce #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (red_ctl),
		.value   (red_val),
		.modulus (modulus),
		.sts     (red_sts),
		.rem     (rem)
	);

	assign op_a     = s_tdata[OPERAND_W-1:0];
	assign op_b     = s_tdata[2*OPERAND_W-1:OPERAND_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign req_ok   = (modulus >= MOD_WIDTH'(2)) &&
		((s_tuser == OP_POWER) || (s_tuser == OP_INVERSE) || (s_tuser == OP_DIVIDE));
	assign out_free = !out_valid_q || m_tready;
	assign mod_m2   = modulus - MOD_WIDTH'(2);

	assign red_ctl.start = (accept && req_ok) || (state_q == S_LOAD);
	assign red_val = (state_q == S_IDLE) ? ((s_tuser == OP_DIVIDE) ? op_b : op_a) : red_q;

	assign mul_x = ((exp_q == '0) || exp_q[0]) ? acc_q : base_q;
	assign prod  = mul_x * base_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_BASE;
			op_q        <= OP_POWER;
			amod_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_WRITE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						amod_q <= 1'b0;
						kind_q <= K_BASE;
						if (req_ok) begin
							op_q    <= op_t'(s_tuser);
							state_q <= S_WAIT;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_STEP: begin
					priority if (exp_q != '0) begin
						kind_q  <= exp_q[0] ? K_ACC : K_SQR;
						state_q <= S_LOAD;
					end else if (op_q == OP_DIVIDE && !amod_q) begin
						kind_q  <= K_AMOD;
						state_q <= S_LOAD;
					end else if (op_q == OP_DIVIDE) begin
						kind_q  <= K_FIN;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_LOAD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (red_sts.done) begin
						if (kind_q == K_AMOD) begin
							amod_q <= 1'b1;
						end
						state_q <= (kind_q == K_FIN) ? S_WRITE : S_STEP;
					end
				end
				S_WRITE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					a_q   <= op_a;
					acc_q <= MOD_WIDTH'(1);
					res_q <= '0;
					exp_q <= (s_tuser == OP_POWER) ? op_b : OPERAND_W'(mod_m2);
				end
			end
			S_STEP: begin
				priority if (exp_q != '0) begin
					red_q <= OPERAND_W'(prod);
				end else if (op_q == OP_DIVIDE && !amod_q) begin
					red_q <= a_q;
				end else if (op_q == OP_DIVIDE) begin
					red_q <= OPERAND_W'(prod);
				end else begin
					res_q <= acc_q;
				end
			end
			S_WAIT: begin
				if (red_sts.done) begin
					unique case (kind_q)
						K_BASE, K_AMOD: begin
							base_q <= rem;
						end
						K_ACC: begin
							acc_q    <= rem;
							exp_q[0] <= 1'b0;
						end
						K_SQR: begin
							base_q <= rem;
							exp_q  <= exp_q >> 1;
						end
						K_FIN: begin
							res_q <= rem;
						end
						default: begin
							res_q <= res_q;
						end
					endcase
				end
			end
			S_WRITE: begin
				if (out_free) begin
					out_q <= RESULT_W'(res_q);
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !red_sts.busy)
		else $error("reducer busy while sequencer idle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		red_sts.done |-> (state_q == S_WAIT))
		else $error("reduction finished outside wait state");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && (modulus >= MOD_WIDTH'(2))) |->
		(out_q < RESULT_W'(modulus)))
		else $error("result not below modulus");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after accepting a transaction");

endmodule

// ----- test/modular_power_inverse_divide_tb.sv -----
`timescale 1ns / 100ps

module modular_power_inverse_divide_tb;
	import mpid_pkg::*;

	localparam int MOD_W = 31;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [REQ_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [OPERAND_W-1:0] ONES = {OPERAND_W{1'b1}};

	typedef struct {
		logic [REQ_W-1:0]     kind;
		logic [OPERAND_W-1:0] a;
		logic [OPERAND_W-1:0] b;
	} mod_request_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // operand_a [62:0], operand_b [125:63]
	logic [REQ_W-1:0]       s_tuser = '0;   // req_type [1:0]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // result [30:0]
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	mod_request_t        pending_requests[$];
	logic [RESULT_W-1:0] expected_residues[$];
	mod_request_t        cur_req;
	logic [RESULT_W-1:0] want_residue;
	logic [MOD_W-1:0]    modulus_copy = DEFAULT_MODULUS;
	int                  burst_left = 1;
	int                  gap_left = 0;
	int                  stall_mode = 0;
	int                  stall_cycle = 0;
	int                  quiet_cycles = 0;
	int                  errors = 0;
	int                  results_checked = 0;
	int                  settings_count = 0;
	int                  op_count[4] = '{0, 0, 0, 0};

	modular_power_inverse_divide u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned raise_mod(longint unsigned base, longint unsigned expo,
			longint unsigned m);
		longint unsigned acc;
		acc = 1;
		base = base % m;
		while (expo != 0) begin
			if ((expo & 1) != 0)
				acc = (acc * base) % m;
			base = (base * base) % m;
			expo = expo >> 1;
		end
		return acc;
	endfunction

	function automatic logic [RESULT_W-1:0] modular_result(logic [REQ_W-1:0] kind,
			logic [OPERAND_W-1:0] a, logic [OPERAND_W-1:0] b, logic [MOD_W-1:0] m);
		longint unsigned mm;
		longint unsigned r;
		mm = m;
		r = 0;
		if (mm >= 2) begin
			case (kind)
				OP_POWER: r = raise_mod(a, b, mm);
				OP_INVERSE: r = raise_mod(a, mm - 2, mm);
				OP_DIVIDE: r = ((a % mm) * raise_mod(b, mm - 2, mm)) % mm;
				default: r = 0;
			endcase
		end
		return r[RESULT_W-1:0];
	endfunction

	function automatic logic [OPERAND_W-1:0] rand_wide(int unsigned bits);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (bits == 0)
			return '0;
		return v[OPERAND_W-1:0] >> (OPERAND_W - bits);
	endfunction

	function automatic logic [OPERAND_W-1:0] rand_operand(logic [MOD_W-1:0] m);
		longint unsigned mult;
		mult = m;
		mult = mult * $urandom_range(0, 1000);
		case ($urandom_range(0, 5))
			0: return rand_wide(OPERAND_W);
			1: return rand_wide(MOD_W);
			2: return mult[OPERAND_W-1:0];
			3: return ($urandom_range(0, 1) != 0) ? ONES : '0;
			default: return rand_wide($urandom_range(0, OPERAND_W));
		endcase
	endfunction

	function automatic void queue_request(logic [REQ_W-1:0] kind, logic [OPERAND_W-1:0] a,
			logic [OPERAND_W-1:0] b);
		mod_request_t req;
		req.kind = kind;
		req.a = a;
		req.b = b;
		pending_requests.insert(pending_requests.size(), req);
	endfunction

	task automatic queue_random(int count);
		int pick;
		logic [REQ_W-1:0] kind;
		logic [OPERAND_W-1:0] b;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			kind = (pick == 0) ? OP_UNUSED : REQ_W'(pick % 3);
			if (kind == OP_POWER)
				b = ($urandom_range(0, 9) == 0) ? rand_wide(OPERAND_W)
					: rand_wide($urandom_range(0, 16));
			else
				b = rand_operand(modulus_copy);
			queue_request(kind, rand_operand(modulus_copy), b);
		end
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_requests.size() != 0 || s_tvalid || expected_residues.size() != 0);
	endtask

	task automatic apb_transfer(input logic wr, input logic [APB_DATA_W-1:0] wdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_ADDR_W'(4 * int'(REG_MODULUS));
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			modulus_copy = wdata[MOD_W-1:0];
		end else if (prdata[MOD_W-1:0] !== modulus_copy) begin
			$display("%0t ns: modulus readback mismatch, expected %0d, actual %0d",
				$time, modulus_copy, prdata[MOD_W-1:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_modulus(input logic [APB_DATA_W-1:0] value);
		wait_drained();
		apb_transfer(1'b0, '0);
		apb_transfer(1'b1, value);
		apb_transfer(1'b0, '0);
		settings_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_residues.insert(expected_residues.size(),
					modular_result(cur_req.kind, cur_req.a, cur_req.b, modulus_copy));
				op_count[cur_req.kind]++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					cur_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_req.b, cur_req.a};
					s_tuser <= cur_req.kind;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 6);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode = 0;
			stall_cycle = 0;
		end else begin
			stall_cycle++;
			if (stall_cycle % 500 == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 2) != 0);
				default: m_tready <= ((stall_cycle % 16) < 11);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_residues.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %0d",
					$time, m_tdata[RESULT_W-1:0]);
				errors++;
			end else begin
				want_residue = expected_residues.pop_front();
				if (m_tdata[RESULT_W-1:0] !== want_residue) begin
					$display("%0t ns: result mismatch, expected %0d, actual %0d",
						$time, want_residue, m_tdata[RESULT_W-1:0]);
					errors++;
				end
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: timeout, no transaction for %0d cycles", $time, quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_request(OP_POWER, '0, '0);
		queue_request(OP_POWER, ONES, '0);
		queue_request(OP_POWER, '0, 63'd5);
		queue_request(OP_POWER, 63'd2, 63'd1);
		queue_request(OP_POWER, 63'd3, 63'h4000_0000_0000_0000);
		queue_request(OP_POWER, ONES, ONES);
		queue_request(OP_POWER, 63'd3000000021, 63'd7);
		queue_request(OP_INVERSE, 63'd1, '0);
		queue_request(OP_INVERSE, 63'd2, ONES);
		queue_request(OP_INVERSE, '0, '0);
		queue_request(OP_INVERSE, 63'd5000000035, '0);
		queue_request(OP_INVERSE, ONES, 63'd12345);
		queue_request(OP_DIVIDE, ONES, ONES);
		queue_request(OP_DIVIDE, '0, 63'd7);
		queue_request(OP_DIVIDE, 63'd10, '0);
		queue_request(OP_DIVIDE, 63'd10, 63'd1000000007);
		queue_request(OP_DIVIDE, 63'd1000000006, 63'd1000000006);
		queue_request(OP_DIVIDE, 63'd6, 63'd3);
		queue_request(OP_UNUSED, ONES, ONES);
		queue_request(OP_UNUSED, '0, '0);

		set_modulus(32'd2147483647);
		queue_random(25);

		set_modulus(32'd2);
		queue_request(OP_INVERSE, 63'd3, '0);
		queue_request(OP_DIVIDE, 63'd5, 63'd4);
		queue_request(OP_DIVIDE, ONES, 63'd1);
		queue_request(OP_POWER, 63'd7, '0);
		queue_random(15);

		set_modulus(32'd3);
		queue_random(15);

		set_modulus(32'd1);
		for (int k = 0; k < 4; k++)
			queue_request(REQ_W'(k), 63'd5, 63'd3);
		queue_random(5);

		set_modulus(32'd0);
		for (int k = 0; k < 4; k++)
			queue_request(REQ_W'(k), ONES, 63'd3);
		queue_random(5);

		set_modulus(32'h8000_FFF1);
		queue_random(25);

		set_modulus(APB_DATA_W'($urandom_range(2, 2147483646)));
		queue_random(25);

		set_modulus(32'd1000000007);
		queue_random(10);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d power, %0d inverse, %0d divide and %0d unused-selector transactions",
			op_count[OP_POWER], op_count[OP_INVERSE], op_count[OP_DIVIDE], op_count[OP_UNUSED]);
		$display("across %0d modulus settings; %0d results checked, %0d errors",
			settings_count, results_checked, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
